// ===== hdl/ffc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffc_pkg;

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_HOP    = 2'd1,
    REG_FREQS  = 2'd2
  } cfg_reg_t;

  // Input item kinds carried on tuser
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_PUSH = 1'b1
  } func_t;

  // Frame sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } ffc_state_t;

  localparam int WIN_W   = 11;
  localparam int HOP_W   = 16;
  localparam int FCNT_W  = 7;
  localparam int SLOT_W  = 6;
  localparam int STEP_W  = 32;
  localparam int SUM_W   = 48;
  localparam int FRAME_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W   = 120;

endpackage
`default_nettype wire

// ===== hdl/frame_fourier_coefficients.sv =====
// Short-time correlation of a sample stream against chosen frequencies. An item with
// tuser FUNC_LOAD stores a 32-bit phase step (f / fs as a fraction of a turn) into a
// frequency slot; an item with FUNC_PUSH appends one signed sample to a ring of the last
// MAX_WINDOW samples. When win_len samples have arrived, and after every
// hop_len further samples, the block evaluates one frame: for each slot below
// freq_count it returns the sums of sample times cosine and sample times sine over the
// window, the phase starting at zero on the oldest sample, with tlast on the final slot.
// One shared multiply-accumulate pair walks the window one sample per cycle, so a frame
// keeps s_tready low while the window is walked once per slot, plus any wait
// for the result register; items that start no frame leave s_tready high. The walk is set
// by the single read port of the sample ring. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module frame_fourier_coefficients #(
  parameter int MAX_WINDOW      = 1024,
  parameter int MAX_FREQS       = 64,
  parameter int SINE_TABLE_SIZE = 1024,
  parameter int SAMPLE_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  // tdata: slot[5:0], phase_step[37:6], sample[38 +: SAMPLE_BITS], zero fill
  input  wire logic [((38 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // tuser: func
  input  wire logic s_tuser,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // tdata: cos_sum[47:0], sin_sum[95:48], freq_index[101:96], frame_index[117:102]
  output logic [ffc_pkg::OUT_W-1:0] m_tdata,
  output logic      m_tlast,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [ffc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ffc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ffc_pkg::*;

  localparam int WP_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int FI_W = (MAX_FREQS > 1) ? $clog2(MAX_FREQS) : 1;
  localparam int NF_W = $clog2(MAX_FREQS + 1);
  localparam int PW   = SAMPLE_BITS + 16;

  // Configuration registers
  logic [WIN_W-1:0]  win_len;
  logic [HOP_W-1:0]  hop_len;
  logic [FCNT_W-1:0] freq_count;

  // Stream state
  logic [WIN_W-1:0]   fill_count;
  logic [HOP_W-1:0]   hop_counter;
  logic [FRAME_W-1:0] frame_counter;
  logic [WP_W-1:0]    write_pointer;

  // Memories
  logic signed [SAMPLE_BITS-1:0] sample_ring [MAX_WINDOW];
  logic [STEP_W-1:0]             step_table  [MAX_FREQS];
  logic signed [SAMPLE_BITS-1:0] ring_q;
  logic [STEP_W-1:0]             step_q;

  // Frame run registers
  ffc_state_t state, state_next;
  logic [NW-1:0]      w_run, n_cnt;
  logic [NF_W-1:0]    nf_run;
  logic [FI_W-1:0]    f_cnt;
  logic [WP_W-1:0]    start_ptr, rd_ptr;
  logic [FRAME_W-1:0] frame_run;
  logic [31:0]        phase;
  logic               v1, v2;
  logic signed [PW-1:0]    prod_c, prod_s;
  logic signed [SUM_W-1:0] acc_c, acc_s;
  logic signed [15:0]      sin_q, cos_q;

  // Decode of the input item
  logic                          in_fire, push_fire, load_fire, frame_go;
  logic [SLOT_W-1:0]             in_slot;
  logic [STEP_W-1:0]             in_step;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [NW-1:0]                 w_eff;
  logic [NF_W-1:0]               nf_eff;
  logic [HOP_W-1:0]              hop_eff, hop_inc;
  logic [WP_W-1:0]               wp_inc, start_new;
  logic                          out_free, issue, last_issue, last_freq;

  assign in_slot   = s_tdata[SLOT_W-1:0];
  assign in_step   = s_tdata[SLOT_W +: STEP_W];
  assign in_sample = s_tdata[SLOT_W + STEP_W +: SAMPLE_BITS];
  assign in_fire   = s_tvalid && s_tready;
  assign push_fire = in_fire && (func_t'(s_tuser) == FUNC_PUSH);
  assign load_fire = in_fire && (func_t'(s_tuser) == FUNC_LOAD);

  // Clamp the registers to what the hardware holds
  assign w_eff   = (win_len == '0) ? NW'(1) :
                   (32'(win_len) > MAX_WINDOW) ? NW'(MAX_WINDOW) : NW'(win_len);
  assign nf_eff  = (freq_count == '0) ? NF_W'(1) :
                   (32'(freq_count) > MAX_FREQS) ? NF_W'(MAX_FREQS) : NF_W'(freq_count);
  assign hop_eff = (hop_len == '0) ? HOP_W'(1) : hop_len;
  assign hop_inc = hop_counter + HOP_W'(1);

  // Ring pointer after this push, and the oldest sample of the window
  assign wp_inc    = (32'(write_pointer) == MAX_WINDOW - 1) ? '0 : write_pointer + WP_W'(1);
  assign start_new = (32'(wp_inc) >= 32'(w_eff)) ? WP_W'(32'(wp_inc) - 32'(w_eff))
                                                 : WP_W'(32'(wp_inc) + MAX_WINDOW
                                                         - 32'(w_eff));

  // A push starts a frame when the window just filled or a hop elapsed
  always_comb begin
    if (32'(fill_count) < 32'(w_eff)) begin
      frame_go = push_fire && (32'(fill_count) + 1 == 32'(w_eff));
    end else begin
      frame_go = push_fire && (hop_inc >= hop_eff);
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_free   = !m_tvalid || m_tready;
  assign last_issue = (n_cnt == w_run - NW'(1));
  assign last_freq  = (NF_W'(f_cnt) == nf_run - NF_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (frame_go) state_next = ST_STEP;
      ST_STEP:  state_next = ST_RUN;
      ST_RUN:   if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: if (!v1 && !v2) state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = last_freq ? ST_IDLE : ST_STEP;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_RUN:  issue    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len    <= WIN_W'(1024);
      hop_len    <= HOP_W'(512);
      freq_count <= FCNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW: win_len    <= cfg_data[WIN_W-1:0];
        REG_HOP:    hop_len    <= cfg_data[HOP_W-1:0];
        REG_FREQS:  freq_count <= cfg_data[FCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Fill, hop and frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      hop_counter   <= '0;
      frame_counter <= '0;
      write_pointer <= '0;
    end else if (push_fire) begin
      write_pointer <= wp_inc;
      if (32'(fill_count) < 32'(w_eff)) begin
        fill_count <= fill_count + WIN_W'(1);
      end else begin
        hop_counter <= hop_inc;
      end
      if (frame_go) begin
        hop_counter   <= '0;
        frame_counter <= frame_counter + FRAME_W'(1);
      end
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (push_fire) sample_ring[write_pointer] <= in_sample;
    ring_q <= sample_ring[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (load_fire && (32'(in_slot) < MAX_FREQS)) step_table[in_slot[FI_W-1:0]] <= in_step;
    step_q <= step_table[f_cnt];
  end

  // Latch the frame's shape at its start
  always_ff @(posedge clk) begin
    if (frame_go) begin
      w_run     <= w_eff;
      nf_run    <= nf_eff;
      start_ptr <= start_new;
      frame_run <= frame_counter;
    end
  end

  // Walk the window: one sample and one phase per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      f_cnt <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (frame_go) f_cnt <= '0;
      else if (state == ST_OUT && out_free && !last_freq) f_cnt <= f_cnt + FI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_STEP) begin
      n_cnt  <= '0;
      rd_ptr <= start_ptr;
      phase  <= '0;
    end else if (issue) begin
      n_cnt  <= n_cnt + NW'(1);
      rd_ptr <= (32'(rd_ptr) == MAX_WINDOW - 1) ? '0 : rd_ptr + WP_W'(1);
      phase  <= phase + step_q;
    end
  end

  ffc_sine_rom #(
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_rom (
    .clk       (clk),
    .phase_sin (phase),
    .phase_cos (phase + 32'h4000_0000),
    .sin_q     (sin_q),
    .cos_q     (cos_q)
  );

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    prod_c <= PW'(ring_q * cos_q);
    prod_s <= PW'(ring_q * sin_q);
    if (state == ST_STEP) begin
      acc_c <= '0;
      acc_s <= '0;
    end else if (v2) begin
      acc_c <= acc_c + SUM_W'(prod_c);
      acc_s <= acc_s + SUM_W'(prod_s);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {2'b0, frame_run, SLOT_W'(f_cnt), acc_s, acc_c};
      m_tlast <= last_freq;
    end
  end

  // Input is held off for the whole frame
  assert property (@(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !s_tready)
    else $error("input accepted during a frame");

  // The window walk never runs past the latched length
  assert property (@(posedge clk) disable iff (rst) (state == ST_RUN) |-> (n_cnt < w_run))
    else $error("window walk overran");

  // The slot counter stays below the latched slot count inside a frame
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (NF_W'(f_cnt) < nf_run))
    else $error("slot counter overran");

  // A result is only loaded after the pipeline has drained
  assert property (@(posedge clk) disable iff (rst) (state == ST_OUT) |-> (!v1 && !v2))
    else $error("result loaded before drain");

endmodule
`default_nettype wire

// ===== hdl/ffc_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffc_sine_rom #(
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic               clk,
  input  wire logic [31:0]        phase_sin,
  input  wire logic [31:0]        phase_cos,
  output logic signed [15:0]      sin_q,
  output logic signed [15:0]      cos_q
);

  localparam int RI_W = $clog2(SINE_TABLE_SIZE);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] rom_t [SINE_TABLE_SIZE];

  // Quarter-wave fold and Taylor series to x^11 in Q2.30, truncating steps
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] u, x, x2, term, v;
    logic signed [63:0] acc;
    logic neg;
    u = 64'(4 * k);
    neg = 1'b0;
    if (u >= 64'(2 * SINE_TABLE_SIZE)) begin
      u = u - 64'(2 * SINE_TABLE_SIZE);
      neg = 1'b1;
    end
    if (u > 64'(SINE_TABLE_SIZE)) u = 64'(2 * SINE_TABLE_SIZE) - u;
    x = (u * HALF_PI_Q30) / 64'(SINE_TABLE_SIZE);
    x2 = (x * x) >> 30;
    acc = signed'(x);
    term = ((x * x2) >> 30) / 64'd6;
    acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc = acc - signed'(term);
    if (acc < 0) acc = 0;
    v = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return neg ? -signed'(16'(v)) : signed'(16'(v));
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) r[k] = sine_entry(k);
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [63:0]     prod_s, prod_c;
  logic [RI_W-1:0] idx_s, idx_c;

  // Scale the phase turn to a table index
  assign prod_s = {32'b0, phase_sin} * 64'(SINE_TABLE_SIZE);
  assign prod_c = {32'b0, phase_cos} * 64'(SINE_TABLE_SIZE);
  assign idx_s  = prod_s[32 +: RI_W];
  assign idx_c  = prod_c[32 +: RI_W];

  always_ff @(posedge clk) begin
    sin_q <= ROM[idx_s];
    cos_q <= ROM[idx_c];
  end

endmodule
`default_nettype wire
